// ----- src/assert_macros.svh -----
// Assertion macros for the rate limiter RTL.
// Depends on nothing; included by the modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/pwrl_pkg.sv -----
// Package of the per-id window rate limiter: field widths, codes and
// controller/datapath interface types. No dependencies.
`timescale 1ns / 1ps

package pwrl_pkg;

   localparam int ID_W    = 32;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int VERD_W  = 2;
   localparam int REQ_DW  = ID_W + TIME_W;
   localparam int RSP_DW  = 8;
   localparam int CSR_AW  = 1;

   localparam logic [CFG_W-1:0] MAX_REQUESTS_RESET   = 16'd1000;
   localparam logic [CFG_W-1:0] WINDOW_SECONDS_RESET = 16'd60;

   localparam logic [CSR_AW-1:0] CSR_MAX_REQUESTS   = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_WINDOW_SECONDS = 1'b1;

   localparam logic [VERD_W-1:0] VERDICT_ALLOWED = 2'd0;
   localparam logic [VERD_W-1:0] VERDICT_LIMITED = 2'd1;
   localparam logic [VERD_W-1:0] VERDICT_FULL    = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] win_base;
      logic [CFG_W-1:0]  allowance;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic start;
      logic advance;
      logic commit_hit;
      logic commit_miss;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_done;
      logic rsp_free;
   } status_type;

endpackage

// ----- src/per_id_window_rate_limiter_top.sv -----
// A request is answered by scanning the table entries in use, one table read per cycle
// until an entry matches, then comparing and committing the verdict once the result
// slot is free. Only one request is taken at a time: the next waits until the
// sequential scan of the single-port entry memory and the commit are done.
// Reset (synchronous, active high) empties the table count and loads
// max_requests 1000 and window_seconds 60; entry memory is not cleared.
`timescale 1ns / 1ps

module per_id_window_rate_limiter_top #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [pwrl_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [pwrl_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [31:0] requester_id, [63:32] current_time
   input  logic [pwrl_pkg::REQ_DW-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [1:0] verdict, [7:2] zero
   output logic [pwrl_pkg::RSP_DW-1:0]   rsp_tdata
);

   pwrl_pkg::cmd_type    cmd;
   pwrl_pkg::status_type status;

   pwrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pwrl_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- src/pwrl_ctrl.sv -----
// Controller of the rate limiter: takes a request, steps the table scan
// and commits the verdict. Depends on pwrl_pkg.
`timescale 1ns / 1ps

module pwrl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pwrl_pkg::status_type  status,
   output pwrl_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit || status.scan_done) begin
               // hold the scan until the result slot is free
               if (status.rsp_free) begin
                  cmd.commit_hit  = status.hit;
                  cmd.commit_miss = !status.hit;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/pwrl_datapath.sv -----
// Datapath of the rate limiter: config registers, entry table memory,
// scan address, window check and result register. Depends on pwrl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwrl_datapath #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [pwrl_pkg::CSR_AW-1:0]         csr_addr,
   input  logic [pwrl_pkg::CFG_W-1:0]          csr_wdata,
   input  logic [pwrl_pkg::REQ_DW-1:0]         req_tdata,
   input  logic                                rsp_tready,
   input  pwrl_pkg::cmd_type                   cmd,
   output pwrl_pkg::status_type                status,
   output logic                                rsp_tvalid,
   output logic [pwrl_pkg::RSP_DW-1:0]         rsp_tdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   logic [pwrl_pkg::CFG_W-1:0]  max_ff, win_ff;
   logic [pwrl_pkg::ID_W-1:0]   id_ff;
   logic [pwrl_pkg::TIME_W-1:0] time_ff;
   logic [CNT_W-1:0]            addr_ff, used_ff;
   logic [IDX_W-1:0]            data_addr_ff;
   logic                        data_valid_ff;
   pwrl_pkg::entry_type         rd_data_ff;
   logic                        rsp_valid_ff;
   logic [pwrl_pkg::VERD_W-1:0] verdict_ff;

   pwrl_pkg::entry_type mem [TABLE_ENTRIES];

   logic [pwrl_pkg::CFG_W-1:0]  reload;
   logic [pwrl_pkg::TIME_W-1:0] elapsed;
   logic                        expired;
   logic                        limited;
   logic                        room;
   logic                        rd_en;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   pwrl_pkg::entry_type         wr_data;
   logic [pwrl_pkg::VERD_W-1:0] verdict_in;
   logic                        insert_en;
   logic                        commit_any;
   logic [CNT_W-1:0]            used_inc;

   assign reload     = (max_ff == '0) ? '0 : max_ff - 1'b1;
   assign elapsed    = time_ff - rd_data_ff.win_base;
   assign expired    = elapsed >= {{(pwrl_pkg::TIME_W - pwrl_pkg::CFG_W){1'b0}}, win_ff};
   assign limited    = !expired && (rd_data_ff.allowance == '0);
   assign room       = used_ff < FULL_COUNT;
   assign rd_en      = cmd.advance && (addr_ff < used_ff);
   assign insert_en  = cmd.commit_miss && room;
   assign commit_any = cmd.commit_hit || cmd.commit_miss;
   assign used_inc   = used_ff + 1'b1;

   assign status.hit       = data_valid_ff && (rd_data_ff.id == id_ff);
   assign status.scan_done = !data_valid_ff && (addr_ff >= used_ff);
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = data_addr_ff;
      wr_data    = rd_data_ff;
      verdict_in = pwrl_pkg::VERDICT_ALLOWED;
      if (cmd.commit_hit) begin
         if (expired) begin
            wr_en             = 1'b1;
            wr_data.allowance = reload;
            wr_data.win_base  = time_ff;
         end else if (limited) begin
            verdict_in = pwrl_pkg::VERDICT_LIMITED;
         end else begin
            wr_en             = 1'b1;
            wr_data.allowance = rd_data_ff.allowance - 1'b1;
         end
      end else begin
         // insert an unknown id, or fail closed when the table is full
         wr_en             = insert_en;
         wr_addr           = used_ff[IDX_W-1:0];
         wr_data.id        = id_ff;
         wr_data.allowance = reload;
         wr_data.win_base  = time_ff;
         if (!room) begin
            verdict_in = pwrl_pkg::VERDICT_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff   <= mem[addr_ff[IDX_W-1:0]];
         data_addr_ff <= addr_ff[IDX_W-1:0];
      end
      if (cmd.start) begin
         id_ff   <= req_tdata[pwrl_pkg::ID_W-1:0];
         time_ff <= req_tdata[pwrl_pkg::REQ_DW-1:pwrl_pkg::ID_W];
      end
      if (commit_any) begin
         verdict_ff <= verdict_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff        <= pwrl_pkg::MAX_REQUESTS_RESET;
         win_ff        <= pwrl_pkg::WINDOW_SECONDS_RESET;
         used_ff       <= '0;
         addr_ff       <= '0;
         data_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               pwrl_pkg::CSR_MAX_REQUESTS:   max_ff <= csr_wdata;
               pwrl_pkg::CSR_WINDOW_SECONDS: win_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.start) begin
            addr_ff       <= '0;
            data_valid_ff <= 1'b0;
         end else if (cmd.advance) begin
            data_valid_ff <= rd_en;
            if (rd_en) begin
               addr_ff <= addr_ff + 1'b1;
            end
         end
         if (insert_en) begin
            used_ff <= used_inc;
         end
         if (commit_any) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pwrl_pkg::RSP_DW - pwrl_pkg::VERD_W){1'b0}}, verdict_ff};

   `ASSERT_CLK(a_used_bound, clock, reset, used_ff <= FULL_COUNT, "entry count too large")
   `ASSERT_CLK(a_used_grow, clock, reset, insert_en |=> used_ff == $past(used_inc), "insert lost")
   `ASSERT_ALWAYS(a_commit_free, clock, commit_any |-> status.rsp_free, "output busy")
   `ASSERT_CLK(a_rsp_set, clock, reset, commit_any |=> rsp_valid_ff, "verdict not presented")

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for per_id_window_rate_limiter_top: drives requests and limit
// settings, predicts each verdict from its own copy of the id table and checks it.
// Depends on pwrl_pkg and the rate limiter RTL only.
`timescale 1ns / 1ps

class verdict_board;
   localparam int SLOTS = 64;

   logic [15:0] max_req;
   logic [15:0] win_len;
   logic [31:0] slot_id [SLOTS];
   logic [15:0] slot_left [SLOTS];
   logic [31:0] slot_start [SLOTS];
   int          slots_used;
   logic [1:0]  verdicts_due [$];
   int          requests_seen;
   int          errors;

   function new();
      max_req = pwrl_pkg::MAX_REQUESTS_RESET;
      win_len = pwrl_pkg::WINDOW_SECONDS_RESET;
      slots_used = 0;
      requests_seen = 0;
      errors = 0;
   endfunction

   function void set_reg(logic [pwrl_pkg::CSR_AW-1:0] addr, logic [15:0] val);
      if (addr == pwrl_pkg::CSR_MAX_REQUESTS) max_req = val;
      else if (addr == pwrl_pkg::CSR_WINDOW_SECONDS) win_len = val;
   endfunction

   function logic [15:0] reload();
      return (max_req == 16'd0) ? 16'd0 : max_req - 16'd1;
   endfunction

   // Update the table for one accepted request and queue the verdict it earns.
   function void predict_verdict(logic [63:0] data);
      logic [31:0] rid;
      logic [31:0] now;
      logic [31:0] elapsed;
      logic [1:0]  verdict;
      int          hit;
      int          i;
      rid = data[31:0];
      now = data[63:32];
      hit = -1;
      for (i = 0; i < slots_used; i++) begin
         if (hit < 0 && slot_id[i] == rid) hit = i;
      end
      if (hit >= 0) begin
         elapsed = now - slot_start[hit];
         if (elapsed >= {16'd0, win_len}) begin
            slot_left[hit] = reload();
            slot_start[hit] = now;
            verdict = pwrl_pkg::VERDICT_ALLOWED;
         end else if (slot_left[hit] == 16'd0) begin
            verdict = pwrl_pkg::VERDICT_LIMITED;
         end else begin
            slot_left[hit] = slot_left[hit] - 16'd1;
            verdict = pwrl_pkg::VERDICT_ALLOWED;
         end
      end else if (slots_used < SLOTS) begin
         slot_id[slots_used] = rid;
         slot_left[slots_used] = reload();
         slot_start[slots_used] = now;
         slots_used++;
         verdict = pwrl_pkg::VERDICT_ALLOWED;
      end else begin
         verdict = pwrl_pkg::VERDICT_FULL;
      end
      verdicts_due.push_back(verdict);
      requests_seen++;
   endfunction

   task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
   endtask

   task check_verdict(logic [7:0] data);
      logic [1:0] want;
      if (verdicts_due.size() == 0) begin
         report_mismatch($sformatf("verdict 0x%02h with no request waiting", data));
      end else begin
         want = verdicts_due.pop_front();
         if (data !== {6'd0, want})
            report_mismatch($sformatf("verdict 0x%02h, expected 0x%02h", data, {6'd0, want}));
      end
   endtask

   task close_out();
      if (verdicts_due.size() != 0)
         report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
   endtask
endclass

module tb_top;

   localparam int TABLE_ENTRIES = 64;
   localparam int ITEM_TOTAL    = 850;
   localparam int QUIET_AFTER   = 760;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE        = TABLE_ENTRIES + 8;
   localparam int STUCK_LIMIT   = 3000;
   localparam int PHASE_LEN     = 60;
   localparam logic [31:0] ID_A = 32'h1234_5678;
   localparam logic [31:0] ID_B = 32'hA5A5_0001;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_wen;
   logic [pwrl_pkg::CSR_AW-1:0]       csr_addr;
   logic [pwrl_pkg::CFG_W-1:0]        csr_wdata;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [pwrl_pkg::REQ_DW-1:0]       req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [pwrl_pkg::RSP_DW-1:0]       rsp_tdata;

   verdict_board board;
   int          items_sent;
   int          stall_left;
   logic        hold_done;
   int          stuck_cycles;
   logic [31:0] id_pool [$];

   per_id_window_rate_limiter_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
      .clock(clock), .reset(reset),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Observe both channels and drive the response side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_done <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) board.predict_verdict(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_verdict(rsp_tdata);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!hold_done && board.requests_seen >= HOLD_AT) begin
            // hold off long enough that the block backs up into the request side
            hold_done <= 1'b1;
            rsp_tready <= 1'b0;
            stall_left <= HOLD_CYCLES;
         end else if (board.requests_seen < QUIET_AFTER && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles < STUCK_LIMIT) begin
         stuck_cycles <= stuck_cycles + 1;
      end else begin
         $display("per_id_window_rate_limiter_top verification failed");
         $finish;
      end
   end

   task automatic send_req(input logic [31:0] rid, input logic [31:0] now);
      if (items_sent < QUIET_AFTER && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {now, rid};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Wait until every verdict is back and the block has gone quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limits(input logic [15:0] max_v, input logic [15:0] win_v);
      csr_wen <= 1'b1;
      csr_addr <= pwrl_pkg::CSR_MAX_REQUESTS;
      csr_wdata <= max_v;
      @(posedge clock);
      csr_addr <= pwrl_pkg::CSR_WINDOW_SECONDS;
      csr_wdata <= win_v;
      @(posedge clock);
      csr_wen <= 1'b0;
      board.set_reg(pwrl_pkg::CSR_MAX_REQUESTS, max_v);
      board.set_reg(pwrl_pkg::CSR_WINDOW_SECONDS, win_v);
   endtask

   initial begin : stimulus
      logic [31:0] hot [4];
      logic [31:0] rid;
      logic [31:0] now_s;
      logic [15:0] max_v;
      logic [15:0] win_v;
      int          r;
      int          n;
      int          k;
      board = new();
      items_sent = 0;
      reset <= 1'b1;
      csr_wen <= 1'b0;
      csr_addr <= pwrl_pkg::CSR_MAX_REQUESTS;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limits: extreme ids and times, elapsed time wrapping past zero
      send_req(32'h0000_0000, 32'h0000_0000);
      send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(32'h0000_0000, 32'hFFFF_FFFF);
      send_req(32'h0000_0000, 32'h0000_0005);
      drain();
      // run out the allowance, then expire exactly at the window edge
      write_limits(16'd2, 16'd10);
      send_req(ID_A, 32'd100);
      send_req(ID_A, 32'd101);
      send_req(ID_A, 32'd102);
      send_req(ID_A, 32'd110);
      drain();
      // zero window: always expired
      write_limits(16'd0, 16'd0);
      send_req(ID_A, 32'd200);
      send_req(ID_A, 32'd200);
      drain();
      // zero maximum: reload saturates at zero
      write_limits(16'd0, 16'hFFFF);
      send_req(ID_B, 32'd300);
      send_req(ID_B, 32'd301);
      send_req(ID_A, 32'd300);
      drain();
      write_limits(16'hFFFF, 16'd1);
      send_req(ID_B, 32'd302);
      send_req(ID_B, 32'd302);
      id_pool = '{32'h0000_0000, 32'hFFFF_FFFF, ID_A, ID_B};

      now_s = 32'hFFFF_FFC0;
      while (items_sent < ITEM_TOTAL) begin
         drain();
         case ($urandom_range(0, 7))
            0: max_v = 16'd0;
            1: max_v = 16'd1;
            2: max_v = 16'hFFFF;
            3: max_v = 16'($urandom());
            default: max_v = 16'($urandom_range(2, 6));
         endcase
         case ($urandom_range(0, 7))
            0: win_v = 16'd0;
            1: win_v = 16'd1;
            2: win_v = 16'hFFFF;
            3: win_v = 16'($urandom());
            default: win_v = 16'($urandom_range(2, 24));
         endcase
         write_limits(max_v, win_v);
         // focus most traffic on a few ids so windows and allowances matter
         for (k = 0; k < 4; k++) hot[k] = id_pool[$urandom_range(0, id_pool.size() - 1)];
         n = ITEM_TOTAL - items_sent;
         if (n > PHASE_LEN) n = PHASE_LEN;
         for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               rid = $urandom();
               id_pool.push_back(rid);
            end else if (r < 80) begin
               rid = hot[2'($urandom_range(0, 3))];
            end else begin
               rid = id_pool[$urandom_range(0, id_pool.size() - 1)];
            end
            r = $urandom_range(0, 19);
            if (r == 0) now_s = $urandom();
            else if (r == 1) now_s = now_s + $urandom_range(16, 70000);
            else now_s = now_s + $urandom_range(0, 2);
            send_req(rid, now_s);
         end
      end

      drain();
      board.close_out();
      if (board.errors == 0)
         $display("per_id_window_rate_limiter_top verification clean");
      else
         $display("per_id_window_rate_limiter_top verification failed");
      $finish;
   end
endmodule
